FILE: rtl/psi_pkg.sv
// shared types and constants for the per-class sparse set index
`timescale 1ns / 1ps

package psi_pkg;

  // default sizing
  localparam int CLASS_COUNT_DEF = 32;
  localparam int SLOT_COUNT_DEF  = 1024;

  // fixed port field widths
  localparam int CLASS_FW = 5;
  localparam int SLOT_FW  = 10;
  localparam int POS_FW   = 10;
  localparam int COUNT_FW = 11;

  // request codes
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } psi_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // register request, read reverse map and count
    logic rd_dense;  // read list at mapped position and at last member
    logic commit;    // write back and load the result register
  } psi_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } psi_status_t;

endpackage

FILE: rtl/psi_ctrl.sv
// controller state machine for the per-class sparse set index
`timescale 1ns / 1ps

module psi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  psi_pkg::psi_status_t  status,
  output psi_pkg::psi_cmd_t     cmd
);

  psi_pkg::psi_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.rd_dense = 1'b0;
    cmd.commit   = 1'b0;
    case (state)
      psi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = psi_pkg::ST_READ;
        end
      end
      psi_pkg::ST_READ: begin
        cmd.rd_dense = 1'b1;
        state_next   = psi_pkg::ST_WRITE;
      end
      psi_pkg::ST_WRITE: begin
        // hold until the result register can take the new result
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = psi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/psi_dp.sv
// datapath for the per-class sparse set index: maps, lists, counts, result register
`timescale 1ns / 1ps

module psi_dp #(
  parameter int CLASS_COUNT = psi_pkg::CLASS_COUNT_DEF,
  parameter int SLOT_COUNT  = psi_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psi_pkg::psi_cmd_t             cmd,
  output psi_pkg::psi_status_t          status,
  input  logic                          req_type,
  input  logic [psi_pkg::CLASS_FW-1:0]  item_class,
  input  logic [psi_pkg::SLOT_FW-1:0]   slot_number,
  input  logic                          remove_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [psi_pkg::POS_FW-1:0]    list_position,
  output logic [psi_pkg::COUNT_FW-1:0]  member_count
);

  localparam int CLS_W = $clog2(CLASS_COUNT);
  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int AW    = CLS_W + IDX_W;
  localparam int DEPTH = 2 ** AW;

  // storage
  logic [IDX_W-1:0] s2p_mem   [DEPTH];
  logic [IDX_W-1:0] dense_mem [DEPTH];
  logic [CNT_W-1:0] cnt_mem   [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] cnt_valid;

  // captured request
  logic             req_r;
  logic             rem_r;
  logic             cls_ok_r;
  logic             slot_ok_r;
  logic [CLS_W-1:0] cls_r;
  logic [IDX_W-1:0] slot_r;

  // registered read data
  logic [IDX_W-1:0] pos_rd;
  logic [CNT_W-1:0] cnt_rd;
  logic             cnt_vld_rd;
  logic [IDX_W-1:0] dpos_rd;
  logic [IDX_W-1:0] last_rd;

  // addresses of the incoming request
  logic [CLS_W-1:0] in_cls;
  logic [IDX_W-1:0] in_slot;
  assign in_cls  = CLS_W'(item_class);
  assign in_slot = IDX_W'(slot_number);

  // current count and membership
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] last_idx;
  logic             member;
  assign cnt      = cnt_vld_rd ? cnt_rd : '0;
  assign last_idx = IDX_W'(cnt - CNT_W'(1));
  assign member   = (CNT_W'(pos_rd) < cnt) && (dpos_rd == slot_r);

  // write-back and result selection
  logic             dense_we, s2p_we, cnt_we, clr_all;
  logic [AW-1:0]    dense_wa, s2p_wa;
  logic [IDX_W-1:0] dense_wd, s2p_wd;
  logic [CNT_W-1:0] cnt_wd;
  logic             res_acc;
  logic [IDX_W-1:0] res_pos;
  logic [CNT_W-1:0] res_cnt;

  always_comb begin
    dense_we = 1'b0;
    s2p_we   = 1'b0;
    cnt_we   = 1'b0;
    clr_all  = 1'b0;
    dense_wa = {cls_r, pos_rd};
    dense_wd = last_rd;
    s2p_wa   = {cls_r, last_rd};
    s2p_wd   = pos_rd;
    cnt_wd   = cnt - CNT_W'(1);
    res_acc  = 1'b0;
    res_pos  = '0;
    res_cnt  = '0;
    if (req_r == psi_pkg::REQ_CLEAR) begin
      clr_all = 1'b1;
      res_acc = 1'b1;
    end else if (!cls_ok_r) begin
      res_acc = 1'b0;
    end else if (!slot_ok_r) begin
      res_cnt = cnt;
    end else if (rem_r) begin
      res_acc = 1'b1;
      res_cnt = cnt;
      if (member) begin
        // move the last member into the freed position
        dense_we = 1'b1;
        s2p_we   = 1'b1;
        cnt_we   = 1'b1;
        res_pos  = pos_rd;
        res_cnt  = cnt - CNT_W'(1);
      end
    end else if (member) begin
      res_acc = 1'b1;
      res_pos = pos_rd;
      res_cnt = cnt;
    end else if (cnt >= CNT_W'(SLOT_COUNT)) begin
      res_cnt = cnt;
    end else begin
      // append at the list end
      dense_we = 1'b1;
      s2p_we   = 1'b1;
      cnt_we   = 1'b1;
      dense_wa = {cls_r, IDX_W'(cnt)};
      dense_wd = slot_r;
      s2p_wa   = {cls_r, slot_r};
      s2p_wd   = IDX_W'(cnt);
      cnt_wd   = cnt + CNT_W'(1);
      res_acc  = 1'b1;
      res_pos  = IDX_W'(cnt);
      res_cnt  = cnt + CNT_W'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= req_type;
      rem_r     <= remove_entry;
      cls_r     <= in_cls;
      slot_r    <= in_slot;
      cls_ok_r  <= (item_class != '0) && (int'(item_class) < CLASS_COUNT);
      slot_ok_r <= int'(slot_number) < SLOT_COUNT;
    end
  end

  // reverse map memory
  always_ff @(posedge clk) begin
    if (cmd.commit && s2p_we) begin
      s2p_mem[s2p_wa] <= s2p_wd;
    end
    if (cmd.capture) begin
      pos_rd <= s2p_mem[{in_cls, in_slot}];
    end
  end

  // dense list memory, two read ports
  always_ff @(posedge clk) begin
    if (cmd.commit && dense_we) begin
      dense_mem[dense_wa] <= dense_wd;
    end
    if (cmd.rd_dense) begin
      dpos_rd <= dense_mem[{cls_r, pos_rd}];
      last_rd <= dense_mem[{cls_r, last_idx}];
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cmd.commit && cnt_we) begin
      cnt_mem[cls_r] <= cnt_wd;
    end
    if (cmd.capture) begin
      cnt_rd <= cnt_mem[in_cls];
    end
  end

  // count valid bits, cleared by reset and by a clear request
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid  <= '0;
      cnt_vld_rd <= 1'b0;
    end else begin
      if (cmd.commit && clr_all) begin
        cnt_valid <= '0;
      end else if (cmd.commit && cnt_we) begin
        cnt_valid[cls_r] <= 1'b1;
      end
      if (cmd.capture) begin
        cnt_vld_rd <= cnt_valid[in_cls];
      end
    end
  end

  // result register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      accepted      <= res_acc;
      list_position <= psi_pkg::POS_FW'(res_pos);
      member_count  <= psi_pkg::COUNT_FW'(res_cnt);
    end
  end

endmodule

FILE: rtl/per_class_sparse_set_index.sv
// top level of the per-class sparse set index
//
// Keeps a sparse set of slot numbers for each class. Input channel
// (in_valid/in_ready) carries one request per transfer: an update that
// inserts, keeps or removes slot_number in class item_class, or a clear
// that empties every class. Output channel (out_valid/out_ready) returns
// one result per request: accepted, list_position and member_count.
// Each request is handled in order: its input transfer reads the reverse
// map and the class count, the read state then reads the dense list at the
// mapped position and at the last member, and the write state writes back
// and loads the result register. The input is refused while a request is
// being read and written back.
// A new request is taken as soon as the previous one has committed, even
// if its result still waits in the output register; if the receiver
// stalls, the write-back step holds until the output register frees up.
// Reset empties all classes at once through per-class valid bits; the
// map and list memories need no clearing pass.
`timescale 1ns / 1ps

module per_class_sparse_set_index #(
  parameter int CLASS_COUNT = psi_pkg::CLASS_COUNT_DEF,
  parameter int SLOT_COUNT  = psi_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [psi_pkg::CLASS_FW-1:0]  item_class,
  input  logic [psi_pkg::SLOT_FW-1:0]   slot_number,
  input  logic                          remove_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [psi_pkg::POS_FW-1:0]    list_position,
  output logic [psi_pkg::COUNT_FW-1:0]  member_count
);

  psi_pkg::psi_cmd_t    cmd;
  psi_pkg::psi_status_t status;

  // sequencing
  psi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and result path
  psi_dp #(
    .CLASS_COUNT (CLASS_COUNT),
    .SLOT_COUNT  (SLOT_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_type      (req_type),
    .item_class    (item_class),
    .slot_number   (slot_number),
    .remove_entry  (remove_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .list_position (list_position),
    .member_count  (member_count)
  );

endmodule

FILE: rtl/psi_checker.sv
// port-level checks for the per-class sparse set index, bound to the top level
`timescale 1ns / 1ps

module psi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          req_type,
  input logic [psi_pkg::CLASS_FW-1:0]  item_class,
  input logic [psi_pkg::SLOT_FW-1:0]   slot_number,
  input logic                          remove_entry,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          accepted,
  input logic [psi_pkg::POS_FW-1:0]    list_position,
  input logic [psi_pkg::COUNT_FW-1:0]  member_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(accepted)
      && $stable(list_position) && $stable(member_count))
    else $error("stalled result changed");

  // one request at a time: busy right after an input transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in flight");

  // a rejected request reports no position
  a_reject_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> list_position == '0)
    else $error("rejected request reports a position");

  // an empty class has no position to report
  a_empty_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && member_count == '0 |-> list_position == '0)
    else $error("position reported for an empty class");

endmodule

bind per_class_sparse_set_index psi_checker u_psi_checker (.*);

FILE: sim/per_class_sparse_set_index_check.sv
// checker for the per-class sparse set index: predicts each result and compares
`timescale 1ns / 1ps

module per_class_sparse_set_index_check
  import psi_pkg::*;
#(
  parameter int CLASS_COUNT = CLASS_COUNT_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 req_type,
  input  logic [CLASS_FW-1:0]  item_class,
  input  logic [SLOT_FW-1:0]   slot_number,
  input  logic                 remove_entry,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 accepted,
  input  logic [POS_FW-1:0]    list_position,
  input  logic [COUNT_FW-1:0]  member_count,
  output int                   fail_count,
  output int                   pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                accepted;
    logic [POS_FW-1:0]   position;
    logic [COUNT_FW-1:0] count;
  } set_result_t;

  // shadow copy of the reverse maps, dense lists and class sizes
  bit [POS_FW-1:0]   position_of [CLASS_COUNT][SLOT_COUNT];
  bit [SLOT_FW-1:0]  member_at   [CLASS_COUNT][SLOT_COUNT];
  bit [COUNT_FW-1:0] class_size  [CLASS_COUNT];

  set_result_t expected_results [$];
  int          mismatches = 0;
  int          waiting    = 0;
  int          results_seen = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  // apply one request to the shadow sets and return the result it should give
  function automatic set_result_t apply_request(logic rq, logic [CLASS_FW-1:0] cls,
                                                logic [SLOT_FW-1:0] slot, logic rem);
    set_result_t       res;
    logic [COUNT_FW-1:0] size;
    logic [POS_FW-1:0] pos;
    logic [SLOT_FW-1:0] last;
    bit                present;
    res = '0;
    if (rq == REQ_CLEAR) begin
      foreach (class_size[c]) class_size[c] = '0;
      res.accepted = 1'b1;
      return res;
    end
    // class zero or beyond the table is refused outright
    if (cls == 0 || cls >= CLASS_COUNT) return res;
    size = class_size[cls];
    res.count = size;
    if (slot >= SLOT_COUNT) return res;
    // membership only trusts the map when it points inside the live list
    pos = position_of[cls][slot];
    present = (pos < size) && (member_at[cls][pos] == slot);
    res.accepted = 1'b1;
    if (rem) begin
      // swap-remove: last member moves into the freed position
      if (present) begin
        last = member_at[cls][POS_FW'(size - COUNT_FW'(1))];
        member_at[cls][pos] = last;
        position_of[cls][last] = pos;
        class_size[cls] = size - COUNT_FW'(1);
        res.position = pos;
        res.count = size - COUNT_FW'(1);
      end
      return res;
    end
    if (!present) begin
      if (size >= SLOT_COUNT) begin
        res.accepted = 1'b0;
        return res;
      end
      pos = size[POS_FW-1:0];
      member_at[cls][pos] = slot;
      position_of[cls][slot] = pos;
      class_size[cls] = size + COUNT_FW'(1);
    end
    res.position = pos;
    res.count = class_size[cls];
    return res;
  endfunction

  // compare result transfers, then queue the prediction for a new request
  always @(posedge clk) begin
    set_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result %0d with nothing expected: accepted=%0d position=%0d count=%0d",
                     $time, results_seen, accepted, list_position, member_count);
        end else begin
          want = expected_results.pop_front();
          if (accepted !== want.accepted || list_position !== want.position ||
              member_count !== want.count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $write("%0t: result %0d mismatch: expected accepted=%0d position=%0d ",
                     $time, results_seen, want.accepted, want.position);
              $display("count=%0d, got accepted=%0d position=%0d count=%0d",
                       want.count, accepted, list_position, member_count);
            end
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(req_type, item_class, slot_number,
                                                 remove_entry));
      waiting = expected_results.size();
    end
  end

endmodule

FILE: sim/per_class_sparse_set_index_test.sv
// top of the per-class sparse set index testbench: clock, stimulus and verdict
`timescale 1ns / 1ps

module per_class_sparse_set_index_test;
  import psi_pkg::*;

  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   RANDOM_ITEMS = 1300;
  localparam int   CALM_FIRST   = 400;
  localparam int   CALM_LAST    = 750;
  localparam int   IDLE_PCT     = 6;
  localparam logic [CLASS_FW-1:0] TOP_CLASS = CLASS_FW'(CLASS_COUNT_DEF - 1);
  localparam logic [SLOT_FW-1:0]  TOP_SLOT  = SLOT_FW'(SLOT_COUNT_DEF - 1);
  localparam logic DO_REMOVE    = 1'b1;
  localparam logic DO_INSERT    = 1'b0;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                req_type;
  logic [CLASS_FW-1:0] item_class;
  logic [SLOT_FW-1:0]  slot_number;
  logic                remove_entry;
  logic                out_valid;
  logic                out_ready;
  logic                accepted;
  logic [POS_FW-1:0]   list_position;
  logic [COUNT_FW-1:0] member_count;

  int fail_count;
  int pending;
  int items_sent = 0;
  int cycle_count = 0;
  int random_start;
  bit calm = 1'b0;

  per_class_sparse_set_index u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .item_class    (item_class),
    .slot_number   (slot_number),
    .remove_entry  (remove_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .list_position (list_position),
    .member_count  (member_count)
  );

  per_class_sparse_set_index_check u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .item_class    (item_class),
    .slot_number   (slot_number),
    .remove_entry  (remove_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .list_position (list_position),
    .member_count  (member_count),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on total cycles
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL per_class_sparse_set_index");
    $finish;
  end

  // receiver stalls at random outside the calm stretch
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // one request transfer, with random idle cycles ahead of it
  task automatic send_request(input logic rq, input logic [CLASS_FW-1:0] cls,
                              input logic [SLOT_FW-1:0] slot, input logic rem);
    bit taken;
    calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= rq;
    item_class   <= cls;
    slot_number  <= slot;
    remove_entry <= rem;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
    end
    @(negedge clk);
    items_sent++;
  endtask

  // inserts and removes on one class over a pool of slots, plus stray requests
  task automatic run_pool_episode();
    logic [SLOT_FW-1:0]  pool [$];
    logic [CLASS_FW-1:0] cls;
    int unsigned         pool_size;
    int unsigned         steps;
    int unsigned         insert_pct;
    int unsigned         pick;
    cls = CLASS_FW'($urandom_range(1, TOP_CLASS));
    pool_size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(2, 16);
    // mix corner slot numbers into the pool
    repeat (pool_size) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        pool.push_back('0);
      else if (pick < 10)
        pool.push_back(TOP_SLOT);
      else if (pick < 15)
        pool.push_back(SLOT_FW'(1) << $urandom_range(0, SLOT_FW - 1));
      else
        pool.push_back(SLOT_FW'($urandom_range(0, TOP_SLOT)));
    end
    steps = $urandom_range(8, 48);
    insert_pct = $urandom_range(35, 80);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 1)
        send_request(REQ_CLEAR, CLASS_FW'($urandom), SLOT_FW'($urandom), 1'($urandom));
      else if (pick < 3)
        send_request(REQ_UPDATE, '0, SLOT_FW'($urandom), 1'($urandom));
      else if (pick < 6)
        send_request(REQ_UPDATE, CLASS_FW'($urandom), SLOT_FW'($urandom), 1'($urandom));
      else
        send_request(REQ_UPDATE, cls, pool[$urandom_range(0, pool_size - 1)],
                     ($urandom_range(0, 99) < insert_pct) ? DO_INSERT : DO_REMOVE);
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_UPDATE;
    item_class   = '0;
    slot_number  = '0;
    remove_entry = DO_INSERT;
    out_ready    = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // clear with every ignored field at its top value
    send_request(REQ_CLEAR, TOP_CLASS, TOP_SLOT, DO_REMOVE);
    // class zero is refused for insert and remove
    send_request(REQ_UPDATE, '0, SLOT_FW'(5), DO_INSERT);
    send_request(REQ_UPDATE, '0, TOP_SLOT, DO_REMOVE);
    // fill class 1 with extreme slots, keep a present one
    send_request(REQ_UPDATE, CLASS_FW'(1), '0, DO_INSERT);
    send_request(REQ_UPDATE, CLASS_FW'(1), TOP_SLOT, DO_INSERT);
    send_request(REQ_UPDATE, CLASS_FW'(1), '0, DO_INSERT);
    send_request(REQ_UPDATE, CLASS_FW'(1), 10'h2aa, DO_INSERT);
    // remove an absent slot, then swap-removes down to empty
    send_request(REQ_UPDATE, CLASS_FW'(1), SLOT_FW'(5), DO_REMOVE);
    send_request(REQ_UPDATE, CLASS_FW'(1), '0, DO_REMOVE);
    send_request(REQ_UPDATE, CLASS_FW'(1), 10'h2aa, DO_REMOVE);
    send_request(REQ_UPDATE, CLASS_FW'(1), TOP_SLOT, DO_REMOVE);
    // the last member must no longer test as present
    send_request(REQ_UPDATE, CLASS_FW'(1), TOP_SLOT, DO_REMOVE);
    // top class, removal of the tail member and reinsert
    send_request(REQ_UPDATE, TOP_CLASS, TOP_SLOT, DO_INSERT);
    send_request(REQ_UPDATE, TOP_CLASS, 10'h155, DO_INSERT);
    send_request(REQ_UPDATE, TOP_CLASS, 10'h155, DO_REMOVE);
    send_request(REQ_UPDATE, TOP_CLASS, 10'h155, DO_INSERT);
    // clear with ignored fields at zero, then stale maps must not count
    send_request(REQ_CLEAR, '0, '0, DO_INSERT);
    send_request(REQ_UPDATE, TOP_CLASS, 10'h155, DO_INSERT);
    send_request(REQ_UPDATE, TOP_CLASS, TOP_SLOT, DO_INSERT);
    send_request(REQ_UPDATE, CLASS_FW'(1), '0, DO_REMOVE);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS)
      run_pool_episode();
    in_valid <= 1'b0;

    // drain, then wait out anything stray
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fail_count == 0 && pending == 0)
      $display("PASS per_class_sparse_set_index");
    else
      $display("FAIL per_class_sparse_set_index");
    $finish;
  end

endmodule

FILE: sim.f
rtl/psi_pkg.sv
rtl/psi_ctrl.sv
rtl/psi_dp.sv
rtl/per_class_sparse_set_index.sv
rtl/psi_checker.sv
sim/per_class_sparse_set_index_check.sv
sim/per_class_sparse_set_index_test.sv
